// ===== rtl/mexp_pkg.sv =====
// ----------------------------------------------------------------------------
// mexp_pkg
// Shared types for the modular exponentiation core: controller states and
// the command and status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package mexp_pkg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_REDUCE,
        S_RED_WB,
        S_CHECK,
        S_MUL,
        S_MUL_WB,
        S_SQR,
        S_SQR_WB,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic load;       // capture a new item and start the base reduction
        logic setup_mul;  // acc = 0, x = result, y = base
        logic setup_sqr;  // acc = 0, x = base, y = base
        logic step;       // one bit of the shift-and-add modular multiply
        logic wr_base;    // base takes the accumulator
        logic wr_res;     // result takes the accumulator
        logic shift_exp;  // drop the exponent bit just used
        logic out_load;   // move the final value into the output register
    } t_dp_cmd;

    typedef struct packed {
        logic exp_bit;    // lowest remaining exponent bit
        logic exp_zero;   // no exponent bits remain
        logic exp_last;   // the lowest remaining bit is the only one set
        logic out_free;   // the output register can take a value this cycle
    } t_dp_stat;

endpackage

// ===== rtl/mexp_if.sv =====
// ----------------------------------------------------------------------------
// mexp_if
// Valid/ready channels of the modular exponentiation core: the request
// channel carries base and exponent, the response channel the power.
// ----------------------------------------------------------------------------
interface mexp_req_if #(
    parameter int WORD_WIDTH = 64
);
    logic                  valid;
    logic                  ready;
    logic [WORD_WIDTH-1:0] base_value;
    logic [WORD_WIDTH-1:0] exponent;

    modport source (output valid, output base_value, output exponent, input ready);
    modport sink   (input valid, input base_value, input exponent, output ready);
endinterface

interface mexp_rsp_if #(
    parameter int WORD_WIDTH = 64
);
    logic                  valid;
    logic                  ready;
    logic [WORD_WIDTH-1:0] power;

    modport source (output valid, output power, input ready);
    modport sink   (input valid, input power, output ready);
endinterface

// ===== rtl/mexp_datapath.sv =====
// ----------------------------------------------------------------------------
// mexp_datapath
// Modulus register, operand registers and a one-bit-per-cycle modular
// multiply step, plus the output register of the response channel.
// ----------------------------------------------------------------------------
module mexp_datapath
    import mexp_pkg::*;
#(
    parameter int WORD_WIDTH = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [WORD_WIDTH-1:0] i_cfg_wdata,
    input  logic [WORD_WIDTH-1:0] i_base_value,
    input  logic [WORD_WIDTH-1:0] i_exponent,
    input  t_dp_cmd               i_cmd,
    output t_dp_stat              o_stat,
    mexp_rsp_if.source            o_rsp
);

    localparam int SW = WORD_WIDTH + 2;

    logic [WORD_WIDTH-1:0] r_mod;
    logic [WORD_WIDTH-1:0] r_base;
    logic [WORD_WIDTH-1:0] r_exp;
    logic [WORD_WIDTH-1:0] r_res;
    logic [WORD_WIDTH-1:0] r_acc;
    logic [WORD_WIDTH-1:0] r_x;
    logic [WORD_WIDTH-1:0] r_y;
    logic                  r_exp_was_zero;
    logic [WORD_WIDTH-1:0] r_out;
    logic                  r_out_valid;

    logic [WORD_WIDTH-1:0] one_mod;
    logic [WORD_WIDTH-1:0] addend;
    logic [SW-1:0]         sum;
    logic [SW-1:0]         mod1;
    logic [SW-1:0]         mod2;
    logic [SW-1:0]         sum_red;
    logic [WORD_WIDTH-1:0] n_acc;

    // One modulo the modulus: zero when the modulus is one.
    assign one_mod = {{(WORD_WIDTH-1){1'b0}}, (r_mod != WORD_WIDTH'(1))};

    // acc < m and x < m, so 2*acc + x stays below 3*m and at most two
    // subtractions of m bring it back into range.
    always_comb begin
        addend  = r_y[WORD_WIDTH-1] ? r_x : '0;
        sum     = {1'b0, r_acc, 1'b0} + {2'b00, addend};
        mod1    = {2'b00, r_mod};
        mod2    = {1'b0, r_mod, 1'b0};
        if (sum >= mod2) begin
            sum_red = sum - mod2;
        end else if (sum >= mod1) begin
            sum_red = sum - mod1;
        end else begin
            sum_red = sum;
        end
        n_acc = sum_red[WORD_WIDTH-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod <= WORD_WIDTH'(1);
        end else if (i_cfg_we) begin
            r_mod <= (i_cfg_wdata == '0) ? WORD_WIDTH'(1) : i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            // The base reduction is a multiply of one by the raw base.
            r_acc          <= '0;
            r_x            <= one_mod;
            r_y            <= i_base_value;
            r_exp          <= i_exponent;
            r_res          <= one_mod;
            r_exp_was_zero <= (i_exponent == '0);
        end else begin
            if (i_cmd.setup_mul) begin
                r_acc <= '0;
                r_x   <= r_res;
                r_y   <= r_base;
            end else if (i_cmd.setup_sqr) begin
                r_acc <= '0;
                r_x   <= r_base;
                r_y   <= r_base;
            end else if (i_cmd.step) begin
                r_acc <= n_acc;
                r_y   <= {r_y[WORD_WIDTH-2:0], 1'b0};
            end
            if (i_cmd.wr_base) begin
                r_base <= r_acc;
            end
            if (i_cmd.wr_res) begin
                r_res <= r_acc;
            end
            if (i_cmd.shift_exp) begin
                r_exp <= {1'b0, r_exp[WORD_WIDTH-1:1]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // A zero exponent answers one, even when the modulus is one.
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out <= r_exp_was_zero ? WORD_WIDTH'(1) : r_res;
        end
    end

    assign o_rsp.valid = r_out_valid;
    assign o_rsp.power = r_out;

    assign o_stat.exp_bit  = r_exp[0];
    assign o_stat.exp_zero = (r_exp == '0);
    assign o_stat.exp_last = (r_exp[WORD_WIDTH-1:1] == '0);
    assign o_stat.out_free = !r_out_valid || o_rsp.ready;

endmodule

// ===== rtl/mexp_controller.sv =====
// ----------------------------------------------------------------------------
// mexp_controller
// Sequences the base reduction, then per exponent bit an optional multiply
// into the result and, except after the highest set bit, a squaring of the base, each one bit per cycle.
// ----------------------------------------------------------------------------
module mexp_controller
    import mexp_pkg::*;
#(
    parameter int WORD_WIDTH = 64
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    localparam int CW = $clog2(WORD_WIDTH);

    t_state          r_state;
    t_state          n_state;
    logic [CW-1:0]   r_cnt;
    logic [CW-1:0]   n_cnt;
    logic            cnt_last;
    logic            stepping;

    assign cnt_last = (r_cnt == CW'(WORD_WIDTH - 1));
    assign stepping = (r_state == S_REDUCE) || (r_state == S_MUL) || (r_state == S_SQR);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // The bit counter idles at zero and wraps after the last bit.
    always_comb begin
        if (stepping && !cnt_last) begin
            n_cnt = r_cnt + CW'(1);
        end else begin
            n_cnt = '0;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_REDUCE;
                end
            end
            S_REDUCE: begin
                o_cmd.step = 1'b1;
                if (cnt_last) begin
                    n_state = S_RED_WB;
                end
            end
            S_RED_WB: begin
                o_cmd.wr_base = 1'b1;
                n_state       = S_CHECK;
            end
            S_CHECK: begin
                if (i_stat.exp_zero) begin
                    n_state = S_FINISH;
                end else if (i_stat.exp_bit) begin
                    o_cmd.setup_mul = 1'b1;
                    n_state         = S_MUL;
                end else begin
                    o_cmd.setup_sqr = 1'b1;
                    n_state         = S_SQR;
                end
            end
            S_MUL: begin
                o_cmd.step = 1'b1;
                if (cnt_last) begin
                    n_state = S_MUL_WB;
                end
            end
            S_MUL_WB: begin
                o_cmd.wr_res = 1'b1;
                // No higher exponent bits remain, so the last squaring is skipped.
                if (i_stat.exp_last) begin
                    n_state = S_FINISH;
                end else begin
                    o_cmd.setup_sqr = 1'b1;
                    n_state         = S_SQR;
                end
            end
            S_SQR: begin
                o_cmd.step = 1'b1;
                if (cnt_last) begin
                    n_state = S_SQR_WB;
                end
            end
            S_SQR_WB: begin
                o_cmd.wr_base   = 1'b1;
                o_cmd.shift_exp = 1'b1;
                n_state         = S_CHECK;
            end
            S_FINISH: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/modular_exponentiation_core.sv =====
// The multiplies and squarings all share a single shift-and-add multiplier.
// One item at a time; the next is accepted while a result waits for transfer.
// Synchronous active-low reset clears control and sets the modulus to 1.
// ----------------------------------------------------------------------------
// modular_exponentiation_core
// Computes base to the exponent modulo a configured modulus by right-to-left
// binary square and multiply with bit-serial modular multiplication.
// ----------------------------------------------------------------------------
module modular_exponentiation_core
    import mexp_pkg::*;
#(
    parameter int WORD_WIDTH = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [WORD_WIDTH-1:0] i_cfg_wdata,
    mexp_req_if.sink              i_req,
    mexp_rsp_if.source            o_rsp
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    mexp_controller #(
        .WORD_WIDTH (WORD_WIDTH)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (i_req.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    mexp_datapath #(
        .WORD_WIDTH (WORD_WIDTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_base_value (i_req.base_value),
        .i_exponent   (i_req.exponent),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .o_rsp        (o_rsp)
    );

endmodule

// ===== rtl/mexp_checker.sv =====
// ----------------------------------------------------------------------------
// mexp_checker
// Port-level checks of the modular exponentiation core, bound to the top.
// ----------------------------------------------------------------------------
module mexp_checker #(
    parameter int WORD_WIDTH = 64
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  i_in_ready,
    input logic                  i_out_valid,
    input logic                  i_out_ready,
    input logic [WORD_WIDTH-1:0] i_out_power
);

    // A result waiting for transfer stays offered.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("response valid dropped before transfer");

    // A waiting result keeps its value.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_power))
        else $error("response power changed while stalled");

    // Nothing is offered in the cycle after a reset edge.
    assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("response valid after reset");

    // Unless a result still waits, none is offered in the cycle after a request is taken.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && !(i_out_valid && !i_out_ready) |=> !i_out_valid)
        else $error("response appeared too early");

endmodule

bind modular_exponentiation_core mexp_checker #(
    .WORD_WIDTH (WORD_WIDTH)
) u_mexp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_req.valid),
    .i_in_ready  (i_req.ready),
    .i_out_valid (o_rsp.valid),
    .i_out_ready (o_rsp.ready),
    .i_out_power (o_rsp.power)
);

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for modular_exponentiation_core. Power requests go
// through a queue-fed driver, and the expected power is worked out with full
// 128-bit products at the moment each request transfers. A monitor compares
// every returned power in order. Both channels pause at random, and the
// modulus is rewritten between phases once the core has gone idle.
// ----------------------------------------------------------------------------
module tb;

    localparam int W = 64;
    // The limit covers the slowest correct run of all 103 items with their
    // stalls and gaps, with a wide margin.
    localparam int CYCLE_LIMIT = 4_000_000;

    typedef enum logic [1:0] {
        OP_JOB,
        OP_MODULUS,
        OP_DRAIN
    } t_work_kind;

    typedef struct {
        t_work_kind     kind;
        logic [W-1:0]   base_value;
        logic [W-1:0]   exponent;
        logic [W-1:0]   modulus;
        bit             calm;
    } t_work;

    typedef struct {
        logic [W-1:0] base_value;
        logic [W-1:0] exponent;
        logic [W-1:0] modulus;
        logic [W-1:0] power;
    } t_power_rec;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    logic         cfg_we = 1'b0;
    logic [W-1:0] cfg_wdata = '0;
    logic         req_valid = 1'b0;
    logic [W-1:0] req_base = '0;
    logic [W-1:0] req_exp = '0;
    logic         rsp_ready = 1'b0;

    t_work      pending[$];
    t_power_rec power_q[$];
    logic [W-1:0] modulus_now = W'(1);
    bit         calm_now = 1'b0;
    int         gap_left = 0;
    int         stall_left = 0;
    int         errors = 0;
    int         cycles = 0;

    mexp_req_if #(.WORD_WIDTH(W)) req_ch ();
    mexp_rsp_if #(.WORD_WIDTH(W)) rsp_ch ();

    assign req_ch.valid      = req_valid;
    assign req_ch.base_value = req_base;
    assign req_ch.exponent   = req_exp;
    assign rsp_ch.ready      = rsp_ready;

    modular_exponentiation_core #(.WORD_WIDTH(W)) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_req       (req_ch),
        .o_rsp       (rsp_ch)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Square and multiply with exact double-width products. A zero exponent
    // gives 1 without any reduction, even for a modulus of 1.
    function automatic logic [W-1:0] mod_power(input logic [W-1:0] base_in,
                                               input logic [W-1:0] exp_in,
                                               input logic [W-1:0] mod_in);
        logic [2*W-1:0] prod;
        logic [2*W-1:0] wide_mod;
        logic [W-1:0]   b;
        logic [W-1:0]   r;
        logic [W-1:0]   e;
        if (exp_in == '0)
            return W'(1);
        wide_mod = {{W{1'b0}}, mod_in};
        b = base_in % mod_in;
        r = W'(1) % mod_in;
        e = exp_in;
        while (e != '0) begin
            if (e[0]) begin
                prod = {{W{1'b0}}, r} * {{W{1'b0}}, b};
                r = W'(prod % wide_mod);
            end
            prod = {{W{1'b0}}, b} * {{W{1'b0}}, b};
            b = W'(prod % wide_mod);
            e = e >> 1;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [W-1:0] got,
                                   input t_power_rec want);
        $display("mismatch: %s: got %h want %h (base %h exp %h mod %h)", what, got,
                 want.power, want.base_value, want.exponent, want.modulus);
        errors++;
    endtask

    task automatic add_job(input logic [W-1:0] b, input logic [W-1:0] e, input bit calm);
        t_work item;
        item = '{kind: OP_JOB, base_value: b, exponent: e, modulus: '0, calm: calm};
        pending = {pending, item};
    endtask

    task automatic add_modulus(input logic [W-1:0] m);
        t_work item;
        item = '{kind: OP_MODULUS, base_value: '0, exponent: '0, modulus: m,
                 calm: 1'b0};
        pending = {pending, item};
    endtask

    task automatic add_drain();
        t_work item;
        item = '{kind: OP_DRAIN, base_value: '0, exponent: '0, modulus: '0,
                 calm: 1'b0};
        pending = {pending, item};
    endtask

    // Request driver: holds each request until it transfers, then idles for a
    // random gap unless calm. Modulus writes and drain points wait for an empty core.
    always @(posedge i_clk) begin : drive
        logic       next_valid;
        logic       next_we;
        t_work      head;
        t_power_rec rec;
        next_valid = req_valid;
        next_we    = 1'b0;
        if (!i_rst_n) begin
            next_valid = 1'b0;
            gap_left   = 0;
        end else begin
            if (req_valid && req_ch.ready) begin
                rec = '{base_value: req_base, exponent: req_exp,
                        modulus: modulus_now,
                        power: mod_power(req_base, req_exp, modulus_now)};
                power_q = {power_q, rec};
                void'(pending.pop_front());
                next_valid = 1'b0;
                if (!calm_now)
                    gap_left = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 60) :
                               (($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 3));
            end
            if (!next_valid) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending.size() != 0) begin
                    head = pending[0];
                    case (head.kind)
                        OP_JOB: begin
                            next_valid = 1'b1;
                            req_base  <= head.base_value;
                            req_exp   <= head.exponent;
                            calm_now  <= head.calm;
                        end
                        OP_MODULUS: begin
                            if (power_q.size() == 0) begin
                                next_we     = 1'b1;
                                cfg_wdata  <= head.modulus;
                                // A zero write saturates to the lowest legal modulus.
                                modulus_now = (head.modulus == '0) ? W'(1) : head.modulus;
                                void'(pending.pop_front());
                            end
                        end
                        OP_DRAIN: begin
                            if (power_q.size() == 0)
                                void'(pending.pop_front());
                        end
                        default: ;
                    endcase
                end
            end
        end
        req_valid <= next_valid;
        cfg_we    <= next_we;
    end

    // Result monitor with random back-pressure.
    always @(posedge i_clk) begin : watch
        t_power_rec want;
        if (!i_rst_n) begin
            stall_left = 0;
            rsp_ready <= 1'b0;
        end else begin
            if (rsp_ch.valid && rsp_ready) begin
                if (power_q.size() == 0) begin
                    want = '{default: '0};
                    report_mismatch("result with none expected", rsp_ch.power, want);
                end else begin
                    want = power_q.pop_front();
                    if (rsp_ch.power !== want.power)
                        report_mismatch("power", rsp_ch.power, want);
                end
            end
            if (stall_left > 0)
                stall_left--;
            else if (!calm_now && $urandom_range(0, 5) == 0)
                stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 200) :
                             $urandom_range(1, 4);
            rsp_ready <= (stall_left == 0);
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("FAIL modular_exponentiation_core");
            $finish;
        end
    end

    initial begin : stimulus
        logic [W-1:0] ones;
        logic [W-1:0] m;
        logic [W-1:0] b;
        logic [W-1:0] e;
        int           w;
        ones = '1;

        // Reset leaves the modulus at 1: nonzero exponents give 0.
        add_job(W'(5), '0, 1'b0);
        add_job(W'(5), W'(3), 1'b0);
        add_job(ones, ones, 1'b0);

        add_modulus(ones);
        add_job('0, '0, 1'b0);
        add_job('0, W'(5), 1'b0);
        add_job(ones, W'(1), 1'b0);
        add_job(ones - W'(1), W'(2), 1'b0);
        add_job(ones - W'(1), ones, 1'b0);
        add_job(W'(2), W'(63), 1'b0);
        add_job({$urandom, $urandom}, ones, 1'b0);
        add_job(W'(1), ones, 1'b0);

        // Zero is written; the core must treat it as a modulus of 1.
        add_modulus('0);
        add_job(W'(7), W'(1), 1'b0);
        add_job(W'(7), '0, 1'b0);

        add_modulus(W'(2));
        add_job(W'(3), ones, 1'b1);
        add_job(W'(4), W'(1), 1'b1);

        add_modulus(64'h8000_0000_0000_0000);
        add_job(ones, W'(2), 1'b0);
        add_job(W'(3), 64'h8000_0000_0000_0000, 1'b0);

        add_modulus({1'b1, 31'($urandom), $urandom} | W'(1));
        add_job({$urandom, $urandom}, {$urandom, $urandom}, 1'b0);
        add_job({$urandom, $urandom}, {$urandom, $urandom}, 1'b0);

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0:       m = {$urandom, $urandom} | 64'h8000_0000_0000_0000;
                1:       m = W'($urandom_range(2, 1000));
                2:       m = 64'd1 << $urandom_range(1, 63);
                3:       m = ones;
                4:       m = {$urandom, $urandom} | W'(1);
                default: m = {32'd0, $urandom};
            endcase
            add_modulus(m);
            for (int n = 0; n < 14; n++) begin
                case ($urandom_range(0, 6))
                    0:       b = '0;
                    1:       b = W'(1);
                    2:       b = m - W'(1);
                    3:       b = m;
                    4:       b = ones;
                    5:       b = W'($urandom_range(0, 255));
                    default: b = {$urandom, $urandom};
                endcase
                // Short exponents dominate to keep the run length sensible.
                case ($urandom_range(0, 9))
                    0, 1, 2: e = {$urandom, $urandom};
                    3, 4, 5, 6: begin
                        w = $urandom_range(1, 16);
                        e = {$urandom, $urandom} >> (W - w);
                    end
                    7:       e = W'($urandom_range(0, 1));
                    8:       e = ones;
                    default: begin
                        w = $urandom_range(17, 63);
                        e = {$urandom, $urandom} >> (W - w);
                    end
                endcase
                add_job(b, e, ph % 3 == 1);
                if (ph == 2 && n == 8)
                    add_drain();
            end
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending.size() != 0 || power_q.size() != 0)
            @(posedge i_clk);
        repeat (4 * W) @(posedge i_clk);

        if (errors == 0)
            $display("PASS modular_exponentiation_core");
        else
            $display("FAIL modular_exponentiation_core");
        $finish;
    end

endmodule
